### sv/osdsp_pkg.sv
// ----------------------------------------------------------------------------
// osdsp_pkg
// Shared types and codes for the one-shot delay slot pool.
// ----------------------------------------------------------------------------
package osdsp_pkg;

  localparam int SLOTS  = 10;
  localparam int SLOT_W = 4;
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = 32;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_START  = 2'd1;
  localparam logic [1:0] CMD_POLL   = 2'd2;
  localparam logic [1:0] CMD_CANCEL = 2'd3;

  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_POLL   = 2'd1;
  localparam logic [1:0] KIND_CANCEL = 2'd2;
  localparam logic [1:0] KIND_NOTICE = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  interval;
    logic              wants_notice;
  } in_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SLOT_W-1:0] slot_id;
    logic              elapsed;
    logic [1:0]        status;
    logic              last;
  } out_t;

  typedef struct packed {
    logic             expire;
    logic [CNT_W-1:0] dec;
  } dec_res_t;

endpackage

### sv/osdsp_dec.sv
// ----------------------------------------------------------------------------
// osdsp_dec
// Shared countdown unit: decrements one slot count and flags expiry.
// ----------------------------------------------------------------------------
module osdsp_dec (
  input  logic [osdsp_pkg::CNT_W-1:0] rem_i,
  input  logic                        active_i,
  output osdsp_pkg::dec_res_t         res_o
);

  localparam int CW = osdsp_pkg::CNT_W;

  always_comb begin
    res_o.expire = active_i & ~|rem_i[CW-1:1];
    res_o.dec    = res_o.expire ? '0 : rem_i - CW'(1);
  end

endmodule

### sv/one_shot_delay_slot_pool_top.sv
// ----------------------------------------------------------------------------
// one_shot_delay_slot_pool_top
// Pool of one-shot delay timers driven by tick/start/poll/cancel commands.
// ----------------------------------------------------------------------------
//  channel | ports                      | handshake
//  --------+----------------------------+----------------------------------
//  input   | start, busy, in_data       | taken when start & !busy
//  result  | out_strobe, out_data       | one-cycle strobe, always taken
//
//  Poll and cancel: handled in idle, reply on the following cycle.
//  Start: walks slots one per cycle until a free one, else replies full.
//  Tick: one slot per cycle through the shared countdown unit, then a
//  flush state that sends the last held notice, if any.
//  Synchronous reset clears all slot flags; no stall from the receiver.
// ----------------------------------------------------------------------------
module one_shot_delay_slot_pool_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  osdsp_pkg::in_t    in_data,
  output logic              out_strobe,
  output osdsp_pkg::out_t   out_data
);

  localparam int NS    = osdsp_pkg::SLOTS;
  localparam int IW    = osdsp_pkg::IDX_W;
  localparam int SW    = osdsp_pkg::SLOT_W;
  localparam int CW    = osdsp_pkg::CNT_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(NS - 1);
  localparam logic [SW:0]   SLOTS_X  = (SW + 1)'(NS);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FLUSH  = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [IW-1:0]      idx_r, idx_nxt;
  logic [NS-1:0]      armed_r, armed_nxt;
  logic [NS-1:0]      done_r, done_nxt;
  logic [NS-1:0]      wanted_r, wanted_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic [IW-1:0]      pend_id_r, pend_id_nxt;
  logic [CW-1:0]      ival_r, ival_nxt;
  logic               wants_r, wants_nxt;
  logic               ov_r, ov_nxt;
  osdsp_pkg::out_t    out_r, out_nxt;

  logic [CW-1:0]      rem_mem [NS];
  logic               rem_we;
  logic [IW-1:0]      rem_wa;
  logic [CW-1:0]      rem_wd;
  logic [CW-1:0]      rem_rd;

  logic               active;
  osdsp_pkg::dec_res_t dres;
  logic               slot_ok;
  logic [IW-1:0]      sidx;

  assign rem_rd  = rem_mem[idx_r];
  assign active  = armed_r[idx_r] & ~done_r[idx_r];
  assign slot_ok = {1'b0, in_data.slot} < SLOTS_X;
  assign sidx    = in_data.slot[IW-1:0];

  osdsp_dec u_dec (
    .rem_i    (rem_rd),
    .active_i (active),
    .res_o    (dres)
  );

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    armed_nxt   = armed_r;
    done_nxt    = done_r;
    wanted_nxt  = wanted_r;
    pend_v_nxt  = pend_v_r;
    pend_id_nxt = pend_id_r;
    ival_nxt    = ival_r;
    wants_nxt   = wants_r;
    ov_nxt      = 1'b0;
    out_nxt     = '0;
    rem_we      = 1'b0;
    rem_wa      = idx_r;
    rem_wd      = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_data.cmd)
            osdsp_pkg::CMD_TICK: begin
              state_nxt  = ST_SCAN;
              idx_nxt    = '0;
              pend_v_nxt = 1'b0;
            end
            osdsp_pkg::CMD_START: begin
              state_nxt = ST_SEARCH;
              idx_nxt   = '0;
              ival_nxt  = in_data.interval;
              wants_nxt = in_data.wants_notice;
            end
            default: begin
              ov_nxt          = 1'b1;
              out_nxt.kind    = (in_data.cmd == osdsp_pkg::CMD_POLL) ?
                                osdsp_pkg::KIND_POLL : osdsp_pkg::KIND_CANCEL;
              out_nxt.slot_id = in_data.slot;
              out_nxt.last    = 1'b1;
              if (!slot_ok) begin
                out_nxt.status = osdsp_pkg::STAT_RANGE;
              end else if ((in_data.cmd == osdsp_pkg::CMD_CANCEL) || done_r[sidx]) begin
                out_nxt.elapsed  = (in_data.cmd == osdsp_pkg::CMD_POLL);
                armed_nxt[sidx]  = 1'b0;
                done_nxt[sidx]   = 1'b0;
                wanted_nxt[sidx] = 1'b0;
                rem_we           = 1'b1;
                rem_wa           = sidx;
              end
            end
          endcase
        end
      end
      ST_SEARCH: begin
        if (!armed_r[idx_r] && !done_r[idx_r]) begin
          state_nxt       = ST_IDLE;
          ov_nxt          = 1'b1;
          out_nxt.kind    = osdsp_pkg::KIND_START;
          out_nxt.slot_id = SW'(idx_r);
          out_nxt.last    = 1'b1;
          if (ival_r == '0) begin
            done_nxt[idx_r] = 1'b1;
          end else begin
            armed_nxt[idx_r]  = 1'b1;
            wanted_nxt[idx_r] = wants_r;
            rem_we            = 1'b1;
            rem_wd            = ival_r;
          end
        end else if (idx_r == LAST_IDX) begin
          state_nxt      = ST_IDLE;
          ov_nxt         = 1'b1;
          out_nxt.kind   = osdsp_pkg::KIND_START;
          out_nxt.status = osdsp_pkg::STAT_FULL;
          out_nxt.last   = 1'b1;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      ST_SCAN: begin
        if (active) begin
          rem_we = 1'b1;
          rem_wd = dres.dec;
        end
        if (dres.expire) begin
          done_nxt[idx_r] = 1'b1;
          if (wanted_r[idx_r]) begin
            wanted_nxt[idx_r] = 1'b0;
            // previous notice goes out now; this one waits to learn if it is last
            if (pend_v_r) begin
              ov_nxt          = 1'b1;
              out_nxt.kind    = osdsp_pkg::KIND_NOTICE;
              out_nxt.slot_id = SW'(pend_id_r);
            end
            pend_v_nxt  = 1'b1;
            pend_id_nxt = idx_r;
          end
        end
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_FLUSH;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      ST_FLUSH: begin
        state_nxt  = ST_IDLE;
        pend_v_nxt = 1'b0;
        if (pend_v_r) begin
          ov_nxt          = 1'b1;
          out_nxt.kind    = osdsp_pkg::KIND_NOTICE;
          out_nxt.slot_id = SW'(pend_id_r);
          out_nxt.last    = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      idx_r    <= '0;
      armed_r  <= '0;
      done_r   <= '0;
      wanted_r <= '0;
      pend_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      armed_r  <= armed_nxt;
      done_r   <= done_nxt;
      wanted_r <= wanted_nxt;
      pend_v_r <= pend_v_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_id_r <= pend_id_nxt;
    ival_r    <= ival_nxt;
    wants_r   <= wants_nxt;
    out_r     <= out_nxt;
  end

  // count store: one write port, read at the scan index
  always_ff @(posedge clk) begin
    if (rem_we) begin
      rem_mem[rem_wa] <= rem_wd;
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = ov_r;
  assign out_data   = out_r;

endmodule

### sv/osdsp_chk.sv
// ----------------------------------------------------------------------------
// osdsp_chk
// Port-level checks for the delay slot pool, bound to the top level.
// ----------------------------------------------------------------------------
module osdsp_chk (
  input logic            clk,
  input logic            rst_n,
  input logic            start,
  input logic            busy,
  input osdsp_pkg::in_t  in_data,
  input logic            out_strobe,
  input osdsp_pkg::out_t out_data
);

  logic acc_reply;
  logic acc_tick;

  assign acc_reply = start && !busy &&
                     (in_data.cmd == osdsp_pkg::CMD_POLL ||
                      in_data.cmd == osdsp_pkg::CMD_CANCEL);
  assign acc_tick  = start && !busy && (in_data.cmd == osdsp_pkg::CMD_TICK);

  a_reply_next: assert property (@(posedge clk) disable iff (!rst_n)
    acc_reply |=> out_strobe && out_data.last && !busy)
    else $error("poll/cancel reply not on next cycle");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc_tick |=> busy && !out_strobe)
    else $error("tick transaction did not hold busy");

  a_notice_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.kind == osdsp_pkg::KIND_NOTICE |->
      out_data.status == osdsp_pkg::STAT_OK && !out_data.elapsed)
    else $error("expiry notice with status or elapsed set");

  a_elapsed_poll: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.elapsed |-> out_data.kind == osdsp_pkg::KIND_POLL)
    else $error("elapsed set outside a poll reply");

  a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.status == osdsp_pkg::STAT_FULL |->
      out_data.kind == osdsp_pkg::KIND_START && out_data.slot_id == '0)
    else $error("full status on wrong reply");

endmodule

bind one_shot_delay_slot_pool_top osdsp_chk u_osdsp_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_data    (in_data),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);

### tb/tb_one_shot_delay_slot_pool_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_one_shot_delay_slot_pool_top
// Self-checking bench for the one-shot delay slot pool.
// Directed transactions hit range errors, zero and maximum intervals, a full
// pool and a tick expiring every slot at once; random traffic then runs in
// phases with different sender idling. A local slot model predicts every
// reply and expiry notice, and each strobed result is checked in order.
// ----------------------------------------------------------------------------
module tb_one_shot_delay_slot_pool_top;
  import osdsp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 2 * SLOTS + 4;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_strobe;
  out_t out_data;

  // local copy of the pool
  bit             slot_armed  [SLOTS];
  bit             slot_done   [SLOTS];
  bit             slot_notify [SLOTS];
  bit [CNT_W-1:0] slot_left   [SLOTS];

  out_t pending_q[$];
  int   errors;
  int   cmd_count;
  int   result_count;
  int   notice_count;
  int   full_count;
  int   range_count;
  int   cycle_count;

  one_shot_delay_slot_pool_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  function automatic out_t reply(input logic [1:0] kind, input logic [SLOT_W-1:0] id,
                                 input logic el, input logic [1:0] st);
    out_t r;
    r.kind    = kind;
    r.slot_id = id;
    r.elapsed = el;
    r.status  = st;
    r.last    = 1'b1;
    return r;
  endfunction

  function automatic void clear_slot(input int s);
    slot_armed[s]  = 1'b0;
    slot_done[s]   = 1'b0;
    slot_notify[s] = 1'b0;
    slot_left[s]   = '0;
  endfunction

  // updates the pool copy and queues the results one command causes
  function automatic void predict_results(input in_t item);
    out_t notes [SLOTS];
    int   n;
    int   free_idx;
    n        = 0;
    free_idx = SLOTS;
    case (item.cmd)
      CMD_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_armed[i] && !slot_done[i]) begin
            if (slot_left[i] <= 1) begin
              slot_left[i] = '0;
              slot_done[i] = 1'b1;
              if (slot_notify[i]) begin
                slot_notify[i] = 1'b0;
                notes[n] = reply(KIND_NOTICE, SLOT_W'(i), 1'b0, STAT_OK);
                notes[n].last = 1'b0;
                n++;
              end
            end else begin
              slot_left[i] = slot_left[i] - 1;
            end
          end
        end
        if (n > 0) notes[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) pending_q.push_back(notes[i]);
      end
      CMD_START: begin
        for (int i = SLOTS - 1; i >= 0; i--)
          if (!slot_armed[i] && !slot_done[i]) free_idx = i;
        if (free_idx == SLOTS) begin
          pending_q.push_back(reply(KIND_START, '0, 1'b0, STAT_FULL));
        end else begin
          if (item.interval == '0) begin
            slot_done[free_idx] = 1'b1;
          end else begin
            slot_armed[free_idx]  = 1'b1;
            slot_done[free_idx]   = 1'b0;
            slot_notify[free_idx] = item.wants_notice;
            slot_left[free_idx]   = item.interval;
          end
          pending_q.push_back(reply(KIND_START, SLOT_W'(free_idx), 1'b0, STAT_OK));
        end
      end
      default: begin
        if (item.slot >= SLOTS) begin
          pending_q.push_back(reply((item.cmd == CMD_POLL) ? KIND_POLL : KIND_CANCEL,
                                    item.slot, 1'b0, STAT_RANGE));
        end else if (item.cmd == CMD_POLL) begin
          if (slot_done[item.slot]) begin
            clear_slot(item.slot);
            pending_q.push_back(reply(KIND_POLL, item.slot, 1'b1, STAT_OK));
          end else begin
            pending_q.push_back(reply(KIND_POLL, item.slot, 1'b0, STAT_OK));
          end
        end else begin
          clear_slot(item.slot);
          pending_q.push_back(reply(KIND_CANCEL, item.slot, 1'b0, STAT_OK));
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_strobe) begin
      result_count++;
      if (out_data.kind == KIND_NOTICE) notice_count++;
      if (out_data.status == STAT_FULL) full_count++;
      if (out_data.status == STAT_RANGE) range_count++;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind %0d slot %0d elapsed %0d status %0d last %0d",
                 $time, out_data.kind, out_data.slot_id, out_data.elapsed,
                 out_data.status, out_data.last);
      end else begin
        want = pending_q.pop_front();
        if (out_data.kind !== want.kind || out_data.slot_id !== want.slot_id ||
            out_data.elapsed !== want.elapsed || out_data.status !== want.status ||
            out_data.last !== want.last) begin
          errors++;
          $display("%0t: mismatch exp kind %0d slot %0d elapsed %0d status %0d last %0d",
                   $time, want.kind, want.slot_id, want.elapsed, want.status, want.last);
          $display("%0t:          got kind %0d slot %0d elapsed %0d status %0d last %0d",
                   $time, out_data.kind, out_data.slot_id, out_data.elapsed,
                   out_data.status, out_data.last);
        end
      end
    end
  end

  function automatic in_t make_cmd(input logic [1:0] cmd, input logic [SLOT_W-1:0] slot,
                                   input logic [CNT_W-1:0] interval, input logic wants);
    in_t c;
    c.cmd          = cmd;
    c.slot         = slot;
    c.interval     = interval;
    c.wants_notice = wants;
    return c;
  endfunction

  function automatic in_t random_cmd();
    int             pick;
    logic [1:0]     cmd;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  ivl;
    pick = $urandom_range(99);
    if (pick < 40)      cmd = CMD_TICK;
    else if (pick < 65) cmd = CMD_START;
    else if (pick < 85) cmd = CMD_POLL;
    else                cmd = CMD_CANCEL;
    if ($urandom_range(99) < 15) slot = SLOT_W'($urandom_range(15, SLOTS));
    else                         slot = SLOT_W'($urandom_range(SLOTS - 1));
    pick = $urandom_range(99);
    if (cmd != CMD_START || pick < 15) ivl = $urandom;
    else if (pick < 30)                ivl = $urandom_range(50);
    else                               ivl = $urandom_range(6);
    return make_cmd(cmd, slot, ivl, 1'($urandom));
  endfunction

  // start is left high on return so back-to-back transactions are possible
  task automatic issue_command(input in_t item);
    @(negedge clk);
    start   <= 1'b1;
    in_data <= item;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    predict_results(item);
    cmd_count++;
  endtask

  task automatic hold_off(input int n);
    if (n > 0) begin
      @(negedge clk);
      start   <= 1'b0;
      in_data <= make_cmd(2'($urandom), SLOT_W'($urandom), $urandom, 1'($urandom));
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    hold_off(1);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic test_range_checks();
    issue_command(make_cmd(CMD_POLL, 4'd10, '0, 1'b0));
    issue_command(make_cmd(CMD_CANCEL, 4'd15, '1, 1'b1));
    issue_command(make_cmd(CMD_POLL, 4'd0, '0, 1'b0));
    issue_command(make_cmd(CMD_CANCEL, 4'd3, '0, 1'b0));
  endtask

  task automatic test_single_delays();
    issue_command(make_cmd(CMD_START, 4'd0, '0, 1'b1));
    issue_command(make_cmd(CMD_TICK, 4'd0, '0, 1'b0));
    issue_command(make_cmd(CMD_POLL, 4'd0, '0, 1'b0));
    issue_command(make_cmd(CMD_START, 4'd0, 32'd1, 1'b1));
    issue_command(make_cmd(CMD_START, 4'd0, '1, 1'b1));
    issue_command(make_cmd(CMD_START, 4'd0, 32'd2, 1'b0));
    issue_command(make_cmd(CMD_TICK, 4'd0, '0, 1'b0));
    issue_command(make_cmd(CMD_POLL, 4'd2, '0, 1'b0));
    issue_command(make_cmd(CMD_TICK, 4'd0, '0, 1'b0));
    issue_command(make_cmd(CMD_POLL, 4'd2, '0, 1'b0));
    issue_command(make_cmd(CMD_CANCEL, 4'd1, '0, 1'b0));
    issue_command(make_cmd(CMD_POLL, 4'd0, '0, 1'b0));
  endtask

  // every slot expires on the same tick, giving the longest notice burst
  task automatic test_full_pool();
    for (int i = 0; i < SLOTS; i++)
      issue_command(make_cmd(CMD_START, SLOT_W'(i), 32'd1, 1'b1));
    issue_command(make_cmd(CMD_START, 4'd0, 32'd5, 1'b1));
    issue_command(make_cmd(CMD_TICK, 4'd0, '0, 1'b0));
    wait_idle();
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct);
    int gap;
    for (int k = 0; k < count; k++) begin
      issue_command(random_cmd());
      gap = 0;
      while ($urandom_range(99) < idle_pct && gap < 30) gap++;
      hold_off(gap);
    end
    wait_idle();
  endtask

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_data     = '0;
    errors      = 0;
    cmd_count   = 0;
    result_count = 0;
    notice_count = 0;
    full_count  = 0;
    range_count = 0;
    cycle_count = 0;
    for (int i = 0; i < SLOTS; i++) clear_slot(i);
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_range_checks();
    test_single_delays();
    test_full_pool();
    test_random_traffic(36, 0);
    test_random_traffic(36, 68);
    test_random_traffic(36, 0);
    test_random_traffic(36, 35);
    wait_idle();

    if (pending_q.size() != 0) begin
      errors += pending_q.size();
      $display("%0t: %0d expected results never arrived", $time, pending_q.size());
    end
    $display("%0d commands issued, %0d results checked", cmd_count, result_count);
    $display("%0d expiry notices, %0d pool-full and %0d range-error replies, %0d errors",
             notice_count, full_count, range_count, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
